@@ rtl/otrb_pkg.sv @@
package otrb_pkg;

  localparam int DEPTH      = 1024;
  localparam int EVENT_BITS = 64;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 11;
  localparam int DATA_W     = 64;
  localparam int IDX_W      = 10;
  localparam int OP_W       = 2;
  localparam int WRAP_W     = 32;
  localparam int SYNC_W     = 32;
  localparam int SLOT_W     = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(1024);
  localparam logic [WRAP_W-1:0] WRAP_MAX  = {WRAP_W{1'b1}};

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic                  is_write;
    logic                  is_read;
    logic [ADDR_W-1:0]     addr;
    logic [EVENT_BITS-1:0] data;
    logic [CNT_W-1:0]      count;
    logic [WRAP_W-1:0]     wrap;
    logic [SYNC_W-1:0]     sync;
  } cmd_t;

endpackage

@@ rtl/otrb_ram.sv @@
module otrb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/otrb_front.sv @@
module otrb_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         capacity_wr_en,
  input  logic [otrb_pkg::CAP_W-1:0]   capacity_wr_data,
  input  logic                         start,
  input  logic                         q_full,
  input  logic [otrb_pkg::OP_W-1:0]    opcode,
  input  logic [otrb_pkg::DATA_W-1:0]  event_data,
  input  logic [otrb_pkg::IDX_W-1:0]   read_index,
  output logic                         push,
  output otrb_pkg::cmd_t               cmd
);
  import otrb_pkg::*;

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      wp, wp_next;
  logic [WRAP_W-1:0]     wrap, wrap_next;
  logic [SYNC_W-1:0]     newest, newest_next;
  logic [CNT_W-1:0]      cap;
  logic [CNT_W-1:0]      count;
  logic [EVENT_BITS-1:0] ev;
  logic [CNT_W-1:0]      start_slot;
  logic [SLOT_W-1:0]     slot;
  logic                  wrapping;

  assign push = start && !q_full;
  assign ev   = event_data[EVENT_BITS-1:0];

  // effective capacity, zero acts as one, clamp to depth
  always_comb begin
    if (capacity == '0) begin
      cap = CNT_W'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = CNT_W'(capacity);
    end
  end

  assign wrapping = (wp >= cap);

  always_comb begin
    wp_next     = wp;
    wrap_next   = wrap;
    newest_next = newest;
    cmd         = '0;
    case (opcode_t'(opcode))
      OP_WRITE: begin
        cmd.is_write = 1'b1;
        cmd.data     = ev;
        if (wrapping) begin
          cmd.addr  = '0;
          wp_next   = CNT_W'(1);
          wrap_next = (wrap == WRAP_MAX) ? wrap : wrap + WRAP_W'(1);
        end else begin
          cmd.addr = wp[ADDR_W-1:0];
          wp_next  = wp + CNT_W'(1);
        end
        newest_next = ev[SYNC_W-1:0];
      end
      OP_CLEAR: begin
        wp_next     = '0;
        wrap_next   = '0;
        newest_next = '0;
      end
      default: begin
      end
    endcase

    // valid count after the operation
    if (wrap_next != '0) begin
      count = cap;
    end else begin
      count = (wp_next < cap) ? wp_next : cap;
    end

    // ordered read: oldest event sits at the pointer once wrapped
    start_slot = (wp < cap) ? wp : '0;
    slot       = SLOT_W'(start_slot) + SLOT_W'(read_index);
    if (slot >= SLOT_W'(cap)) begin
      slot = slot - SLOT_W'(cap);
    end
    if (opcode_t'(opcode) == OP_READ && 32'(read_index) < 32'(count)) begin
      cmd.is_read = 1'b1;
      cmd.addr    = (wrap != '0) ? slot[ADDR_W-1:0] : ADDR_W'(read_index);
    end

    cmd.count = count;
    cmd.wrap  = wrap_next;
    cmd.sync  = (count == '0) ? '0 : newest_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      wp       <= '0;
      wrap     <= '0;
      newest   <= '0;
    end else begin
      if (capacity_wr_en) begin
        capacity <= capacity_wr_data;
      end
      if (push) begin
        wp     <= wp_next;
        wrap   <= wrap_next;
        newest <= newest_next;
      end
    end
  end

endmodule

@@ rtl/otrb_queue.sv @@
module otrb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  otrb_pkg::cmd_t cmd_in,
  input  logic           pop,
  output otrb_pkg::cmd_t cmd_out,
  output logic           full,
  output logic           empty
);
  import otrb_pkg::*;

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] fill;
  logic               do_push, do_pop;

  assign full    = (fill == Q_CNT_W'(Q_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == Q_DEPTH - 1) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == Q_DEPTH - 1) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + Q_CNT_W'(1);
        2'b01:   fill <= fill - Q_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/otrb_back.sv @@
module otrb_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  otrb_pkg::cmd_t               cmd,
  output logic                         pop,
  output logic                         done,
  output logic [otrb_pkg::DATA_W-1:0]  read_data,
  output logic                         index_valid,
  output logic [otrb_pkg::CAP_W-1:0]   num_events,
  output logic [otrb_pkg::WRAP_W-1:0]  wrap_total,
  output logic [otrb_pkg::SYNC_W-1:0]  newest_stamp
);
  import otrb_pkg::*;

  logic                  stg_valid;
  logic                  stg_read;
  logic [CNT_W-1:0]      stg_count;
  logic [WRAP_W-1:0]     stg_wrap;
  logic [SYNC_W-1:0]     stg_sync;
  logic [EVENT_BITS-1:0] ram_rdata;

  // the receiver never stalls, so drain whenever something waits
  assign pop = !q_empty;

  otrb_ram #(
    .WIDTH (EVENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (pop && cmd.is_write),
    .addr  (cmd.addr),
    .wdata (cmd.data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      stg_read  <= 1'b0;
    end else begin
      stg_valid <= pop;
      stg_read  <= pop && cmd.is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      stg_count <= cmd.count;
      stg_wrap  <= cmd.wrap;
      stg_sync  <= cmd.sync;
    end
  end

  assign done         = stg_valid;
  assign read_data    = stg_read ? DATA_W'(ram_rdata) : '0;
  assign index_valid  = stg_read;
  assign num_events   = CAP_W'(stg_count);
  assign wrap_total   = stg_wrap;
  assign newest_stamp = stg_sync;

endmodule

@@ rtl/overwrite_trace_ring_buffer_unit.sv @@
// a transaction is registered in the queue, then in the back stage, before its result shows
// throughput: one transaction per cycle; the back pops each waiting entry, so the queue never
// holds more than one entry and busy stays low
// the receiver cannot stall: done marks each result for exactly one cycle
// reset (rst, synchronous): clears write pointer, wrap counter, newest word, queue
// and pipeline; capacity returns to 1024. the event store is not cleared, so there
// is no clearing pass and the block accepts transactions right after reset
module overwrite_trace_ring_buffer_unit (
  input  logic                         clk,
  input  logic                         rst,
  // capacity register write
  input  logic                         capacity_wr_en,
  input  logic [otrb_pkg::CAP_W-1:0]   capacity_wr_data,
  // command side
  input  logic                         start,
  output logic                         busy,
  input  logic [otrb_pkg::OP_W-1:0]    opcode,
  input  logic [otrb_pkg::DATA_W-1:0]  event_data,
  input  logic [otrb_pkg::IDX_W-1:0]   read_index,
  // result side
  output logic                         done,
  output logic [otrb_pkg::DATA_W-1:0]  read_data,
  output logic                         index_valid,
  output logic [otrb_pkg::CAP_W-1:0]   num_events,
  output logic [otrb_pkg::WRAP_W-1:0]  wrap_total,
  output logic [otrb_pkg::SYNC_W-1:0]  newest_stamp
);
  import otrb_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t front_cmd;
  cmd_t back_cmd;

  // busy only when the queue between front and back is full
  assign busy = q_full;

  // front: classifies each transaction, owns pointer, wrap counter, newest word
  // and the capacity register; resolves the ring slot of an ordered read
  otrb_front u_front (
    .clk              (clk),
    .rst              (rst),
    .capacity_wr_en   (capacity_wr_en),
    .capacity_wr_data (capacity_wr_data),
    .start            (start),
    .q_full           (q_full),
    .opcode           (opcode),
    .event_data       (event_data),
    .read_index       (read_index),
    .push             (push),
    .cmd              (front_cmd)
  );

  // short queue decouples the front from the memory side
  otrb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (front_cmd),
    .pop     (pop),
    .cmd_out (back_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: one event store access per transaction, then the result strobe
  otrb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .cmd          (back_cmd),
    .pop          (pop),
    .done         (done),
    .read_data    (read_data),
    .index_valid  (index_valid),
    .num_events   (num_events),
    .wrap_total   (wrap_total),
    .newest_stamp (newest_stamp)
  );

`ifndef SYNTHESIS
  // every accepted transaction yields its result after the queue entry and the back stage register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction produced no result");

  // no result claims more events than the store holds
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(num_events) <= DEPTH))
    else $error("event count beyond depth");

  // invalid or non-read results carry zero data
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (done && !index_valid) |-> (read_data == '0))
    else $error("read data not zero without a valid index");

  // empty buffer reports no sync word and no valid index
  a_empty_sync: assert property (@(posedge clk) disable iff (rst)
    (done && num_events == '0) |-> (newest_stamp == '0 && !index_valid))
    else $error("empty buffer reports sync word or valid index");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

// expected outcome of one transaction: the five result ports
typedef struct packed {
  logic [otrb_pkg::DATA_W-1:0] data;
  logic                        valid;
  logic [otrb_pkg::CAP_W-1:0]  count;
  logic [otrb_pkg::WRAP_W-1:0] wraps;
  logic [otrb_pkg::SYNC_W-1:0] sync_word;
} trace_result_t;

class trace_scoreboard;
  logic [otrb_pkg::EVENT_BITS-1:0] ev_store [otrb_pkg::DEPTH];
  bit                              ev_written [otrb_pkg::DEPTH];
  logic [otrb_pkg::CAP_W-1:0]      wr_ptr;
  logic [otrb_pkg::WRAP_W-1:0]     wraps;
  logic [otrb_pkg::SYNC_W-1:0]     newest;
  logic [otrb_pkg::CAP_W-1:0]      cap_reg;
  trace_result_t                   expected_q [$];
  int                              fails;

  function new();
    wr_ptr  = '0;
    wraps   = '0;
    newest  = '0;
    cap_reg = otrb_pkg::CAP_RESET;
    fails   = 0;
    foreach (ev_written[i]) ev_written[i] = 1'b0;
  endfunction

  // capacity as the ring uses it: zero acts as one, above depth acts as depth
  function int slots();
    if (cap_reg == 0) return 1;
    if (cap_reg > otrb_pkg::DEPTH) return otrb_pkg::DEPTH;
    return int'(cap_reg);
  endfunction

  function int valid_events();
    int cap;
    cap = slots();
    if (wraps != 0) return cap;
    return (int'(wr_ptr) < cap) ? int'(wr_ptr) : cap;
  endfunction

  // physical slot of the event at a logical index from the oldest
  function int slot_of(int idx);
    int cap;
    int oldest;
    int s;
    cap = slots();
    if (wraps == 0) return idx;
    oldest = (int'(wr_ptr) < cap) ? int'(wr_ptr) : 0;
    s = oldest + idx;
    if (s >= cap) s -= cap;
    return s;
  endfunction

  // false if a read would land on a slot never written since reset
  function bit read_is_safe(int idx);
    if (idx >= valid_events()) return 1'b1;
    return ev_written[slot_of(idx)];
  endfunction

  function void set_capacity(logic [otrb_pkg::CAP_W-1:0] v);
    cap_reg = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // update the ring for one accepted transaction and queue its result
  function void note(logic [otrb_pkg::OP_W-1:0] op, logic [otrb_pkg::DATA_W-1:0] ev,
                     logic [otrb_pkg::IDX_W-1:0] idx);
    int cap;
    int cnt;
    trace_result_t r;
    cap = slots();
    r = '0;
    if (op == otrb_pkg::OP_WRITE) begin
      if (int'(wr_ptr) >= cap) begin
        ev_store[0]   = ev;
        ev_written[0] = 1'b1;
        wr_ptr        = otrb_pkg::CAP_W'(1);
        if (wraps != otrb_pkg::WRAP_MAX) wraps++;
      end else begin
        ev_store[wr_ptr]   = ev;
        ev_written[wr_ptr] = 1'b1;
        wr_ptr++;
      end
      newest = ev[31:0];
    end else if (op == otrb_pkg::OP_CLEAR) begin
      wr_ptr = '0;
      wraps  = '0;
      newest = '0;
    end
    cnt = valid_events();
    if (op == otrb_pkg::OP_READ && int'(idx) < cnt) begin
      r.data  = ev_store[slot_of(int'(idx))];
      r.valid = 1'b1;
    end
    r.count     = cnt[otrb_pkg::CAP_W-1:0];
    r.wraps     = wraps;
    r.sync_word = (cnt == 0) ? '0 : newest;
    expected_q.push_back(r);
  endfunction

  task report(string what);
    if (fails < 40) $display("mismatch: %s", what);
    fails++;
  endtask

  task check(logic [otrb_pkg::DATA_W-1:0] data, logic valid, logic [otrb_pkg::CAP_W-1:0] count,
             logic [otrb_pkg::WRAP_W-1:0] wraps_got, logic [otrb_pkg::SYNC_W-1:0] sync_got);
    trace_result_t e;
    if (expected_q.size() == 0) begin
      report("result with no transaction outstanding");
      return;
    end
    e = expected_q.pop_front();
    if (data !== e.data)
      report($sformatf("read_data got %h expected %h", data, e.data));
    if (valid !== e.valid)
      report($sformatf("index_valid got %b expected %b", valid, e.valid));
    if (count !== e.count)
      report($sformatf("num_events got %0d expected %0d", count, e.count));
    if (wraps_got !== e.wraps)
      report($sformatf("wrap_total got %0d expected %0d", wraps_got, e.wraps));
    if (sync_got !== e.sync_word)
      report($sformatf("newest_stamp got %h expected %h", sync_got, e.sync_word));
  endtask
endclass

module testbench;

  // the opcode the block must ignore
  localparam logic [otrb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  // generous bound: 711 transactions at worst-case gaps plus drains
  localparam int CYCLE_LIMIT  = 400000;
  // extra settle time once every outstanding result has come back
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 85;

  logic clk;
  logic rst = 1'b1;
  logic capacity_wr_en = 1'b0;
  logic [otrb_pkg::CAP_W-1:0] capacity_wr_data = '0;
  logic start = 1'b0;
  logic [otrb_pkg::OP_W-1:0] opcode = '0;
  logic [otrb_pkg::DATA_W-1:0] event_data = '0;
  logic [otrb_pkg::IDX_W-1:0] read_index = '0;
  logic busy;
  logic done;
  logic [otrb_pkg::DATA_W-1:0] read_data;
  logic index_valid;
  logic [otrb_pkg::CAP_W-1:0] num_events;
  logic [otrb_pkg::WRAP_W-1:0] wrap_total;
  logic [otrb_pkg::SYNC_W-1:0] newest_stamp;

  trace_scoreboard sb;
  int cycles = 0;
  bit gaps_on = 1'b0;

  // capacities for phases 0 to 6 (the last draws one); both register extremes included
  logic [otrb_pkg::CAP_W-1:0] phase_caps [8] = '{11'd4, 11'd0, 11'd2047, 11'd1, 11'd1023,
                                                 11'd2, 11'd1025, 11'd5};

  overwrite_trace_ring_buffer_unit dut (
    .clk              (clk),
    .rst              (rst),
    .capacity_wr_en   (capacity_wr_en),
    .capacity_wr_data (capacity_wr_data),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .event_data       (event_data),
    .read_index       (read_index),
    .done             (done),
    .read_data        (read_data),
    .index_valid      (index_valid),
    .num_events       (num_events),
    .wrap_total       (wrap_total),
    .newest_stamp     (newest_stamp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // results: one strobe per result, sampled with pre-edge values
  always @(posedge clk) begin
    if (!rst && done) sb.check(read_data, index_valid, num_events, wrap_total, newest_stamp);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [otrb_pkg::DATA_W-1:0] rand_event();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // one transaction: hold start until accepted, then maybe idle
  task automatic send(logic [otrb_pkg::OP_W-1:0] op, logic [otrb_pkg::DATA_W-1:0] ev,
                      logic [otrb_pkg::IDX_W-1:0] idx);
    int gap;
    // never read a slot that holds nothing yet; turn such a read into a write
    if (op == otrb_pkg::OP_READ && !sb.read_is_safe(int'(idx))) op = otrb_pkg::OP_WRITE;
    start      <= 1'b1;
    opcode     <= op;
    event_data <= ev;
    read_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(op, ev, idx);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // capacity changes only with the block idle
  task automatic write_capacity(logic [otrb_pkg::CAP_W-1:0] v);
    drain();
    capacity_wr_en   <= 1'b1;
    capacity_wr_data <= v;
    @(posedge clk);
    capacity_wr_en <= 1'b0;
    sb.set_capacity(v);
  endtask

  // writes dominate so the ring fills and wraps; reads mostly aim at valid indexes
  task automatic random_phase(int n_items, logic [otrb_pkg::CAP_W-1:0] cap);
    int r;
    int cnt;
    logic [otrb_pkg::OP_W-1:0] op;
    logic [otrb_pkg::IDX_W-1:0] idx;
    write_capacity(cap);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n_items; i++) begin
      r   = $urandom_range(0, 99);
      cnt = sb.valid_events();
      idx = otrb_pkg::IDX_W'($urandom_range(0, 1023));
      if (r < 52) begin
        op = otrb_pkg::OP_WRITE;
      end else if (r < 88) begin
        op = otrb_pkg::OP_READ;
        if (cnt > 0 && $urandom_range(0, 3) != 0)
          idx = otrb_pkg::IDX_W'($urandom_range(0, cnt - 1));
      end else if (r < 94) begin
        op = otrb_pkg::OP_CLEAR;
      end else begin
        op = OP_UNUSED;
      end
      send(op, rand_event(), idx);
      // at random, hold off mid-phase until the pipeline is empty
      if (i == n_items / 2 && $urandom_range(0, 1) == 1) drain();
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty buffer, unused opcode, extreme event words
    send(otrb_pkg::OP_READ, '0, 10'd0);
    send(OP_UNUSED, '1, '1);
    send(otrb_pkg::OP_WRITE, '1, '0);
    send(otrb_pkg::OP_WRITE, '0, '0);
    send(otrb_pkg::OP_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 10'h2AA);
    send(otrb_pkg::OP_READ, '0, 10'd0);
    send(otrb_pkg::OP_READ, '0, 10'd2);
    send(otrb_pkg::OP_READ, '0, 10'd3);
    send(otrb_pkg::OP_READ, '0, 10'd1023);
    send(otrb_pkg::OP_CLEAR, '1, '0);
    send(otrb_pkg::OP_READ, '0, 10'd0);

    // small ring: wrap until the pointer stands at capacity, oldest then in slot 0
    write_capacity(11'd3);
    send(otrb_pkg::OP_WRITE, 64'h5555_5555_5555_5555, 10'h155);
    for (int i = 0; i < 5; i++) send(otrb_pkg::OP_WRITE, rand_event(), '0);
    send(otrb_pkg::OP_READ, '0, 10'd0);
    send(otrb_pkg::OP_READ, '0, 10'd2);
    send(otrb_pkg::OP_READ, '0, 10'd3);

    // zero capacity acts as one slot
    write_capacity(11'd0);
    send(otrb_pkg::OP_READ, '0, 10'd0);
    send(otrb_pkg::OP_WRITE, rand_event(), '0);

    // pointer left beyond a lowered capacity: count limited, next write wraps
    write_capacity(11'd1024);
    send(otrb_pkg::OP_CLEAR, '0, '0);
    for (int i = 0; i < 4; i++) send(otrb_pkg::OP_WRITE, rand_event(), '0);
    write_capacity(11'd2);
    send(otrb_pkg::OP_READ, '0, 10'd1);
    send(otrb_pkg::OP_WRITE, rand_event(), '0);
    send(otrb_pkg::OP_READ, '0, 10'd0);
    send(otrb_pkg::OP_READ, '0, 10'd1);

    // random phases over several capacities
    for (int p = 0; p < 8; p++) begin
      if (p == 7) random_phase(PHASE_ITEMS, 11'($urandom_range(3, 40)));
      else random_phase(PHASE_ITEMS, phase_caps[p]);
    end

    drain();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
